### hdl/tdph_pkg.sv
package tdph_pkg;

  localparam int POS_W      = 32;
  localparam int BINS_REG_W = 7;
  localparam int INV_W      = 32;
  localparam int RD_IDX_W   = 6;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BINS_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WID_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WID_Y = 2'd3;

  localparam logic [BINS_REG_W-1:0] BINS_RESET    = 7'd64;
  localparam logic [INV_W-1:0]      INV_WID_RESET = 32'd65536;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic capture;
    logic mul_en;
    logic idx_en;
    logic rd_en;
    logic upd_en;
    logic clr_en;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } ctl_sts_t;

endpackage

### hdl/tdph_ram.sv
module tdph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/tdph_ctrl.sv
module tdph_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tdph_pkg::ctl_sts_t  sts,
  output tdph_pkg::ctl_cmd_t  cmd,
  output logic                busy
);
  import tdph_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_IDX   = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_WR    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_MUL;
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_MUL:   state_nxt = ST_IDX;
      ST_IDX:   state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_WR;
      ST_WR:    state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd.capture = (state_r == ST_IDLE) && start;
    cmd.mul_en  = (state_r == ST_MUL);
    cmd.idx_en  = (state_r == ST_IDX);
    cmd.rd_en   = (state_r == ST_RD);
    cmd.upd_en  = (state_r == ST_WR);
    cmd.clr_en  = (state_r == ST_CLEAR);
  end

  assign busy = (state_r != ST_IDLE);

endmodule

### hdl/tdph_dp.sv
module tdph_dp #(
  parameter int MAX_BINS_X = 64,
  parameter int MAX_BINS_Y = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tdph_pkg::ctl_cmd_t                  cmd,
  output tdph_pkg::ctl_sts_t                  sts,
  input  logic                                cfg_we,
  input  logic [tdph_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tdph_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_cmd,
  input  logic [tdph_pkg::POS_W-1:0]          in_x_position,
  input  logic [tdph_pkg::POS_W-1:0]          in_y_position,
  input  logic [tdph_pkg::RD_IDX_W-1:0]       in_read_bin_x,
  input  logic [tdph_pkg::RD_IDX_W-1:0]       in_read_bin_y,
  output logic                                out_strobe,
  output logic [tdph_pkg::OUT_W-1:0]          out_bin_count
);
  import tdph_pkg::*;

  localparam int XB    = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
  localparam int YB    = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;
  localparam int AW    = XB + YB;
  localparam int DEPTH = 2 ** AW;

  logic [BINS_REG_W-1:0] bins_x_r, bins_y_r;
  logic [INV_W-1:0]      inv_x_r, inv_y_r;

  logic                  cmd_r;
  logic [POS_W-1:0]      xpos_r, ypos_r;
  logic [RD_IDX_W-1:0]   rbx_r, rby_r;
  logic [63:0]           x_prod_r, y_prod_r;
  logic [AW-1:0]         addr_r;
  logic                  valid_r;
  logic [AW-1:0]         clr_addr_r;
  logic                  out_strobe_r;
  logic [OUT_W-1:0]      out_count_r;

  logic [31:0]           use_x, use_y, idx_x, idx_y, bx32, by32, rx32, ry32;
  logic                  rd_ok;
  logic [AW-1:0]         addr_nxt;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, sat_inc;
  logic [63:0]           cnt_ext;
  logic [OUT_W-1:0]      cnt_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_x_r <= BINS_RESET;
      bins_y_r <= BINS_RESET;
      inv_x_r  <= INV_WID_RESET;
      inv_y_r  <= INV_WID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BINS_X:    bins_x_r <= cfg_wdata[BINS_REG_W-1:0];
        REG_BINS_Y:    bins_y_r <= cfg_wdata[BINS_REG_W-1:0];
        REG_INV_WID_X: inv_x_r  <= cfg_wdata[INV_W-1:0];
        REG_INV_WID_Y: inv_y_r  <= cfg_wdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // bins in use per axis
  always_comb begin
    if (bins_x_r == '0) begin
      use_x = 32'd1;
    end else if (32'(bins_x_r) > 32'(MAX_BINS_X)) begin
      use_x = 32'(MAX_BINS_X);
    end else begin
      use_x = 32'(bins_x_r);
    end
    if (bins_y_r == '0) begin
      use_y = 32'd1;
    end else if (32'(bins_y_r) > 32'(MAX_BINS_Y)) begin
      use_y = 32'(MAX_BINS_Y);
    end else begin
      use_y = 32'(bins_y_r);
    end
  end

  always_comb begin
    idx_x = x_prod_r[63:32];
    idx_y = y_prod_r[63:32];
    bx32  = (idx_x >= use_x) ? (use_x - 32'd1) : idx_x;
    by32  = (idx_y >= use_y) ? (use_y - 32'd1) : idx_y;
    rx32  = 32'(rbx_r);
    ry32  = 32'(rby_r);
    rd_ok = (rx32 < 32'(MAX_BINS_X)) && (ry32 < 32'(MAX_BINS_Y));
    if (cmd_r == CMD_READ) begin
      addr_nxt = {rx32[XB-1:0], ry32[YB-1:0]};
    end else begin
      addr_nxt = {bx32[XB-1:0], by32[YB-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_cmd;
      xpos_r <= in_x_position;
      ypos_r <= in_y_position;
      rbx_r  <= in_read_bin_x;
      rby_r  <= in_read_bin_y;
    end
    if (cmd.mul_en) begin
      x_prod_r <= 64'(xpos_r) * 64'(inv_x_r);
      y_prod_r <= 64'(ypos_r) * 64'(inv_y_r);
    end
    if (cmd.idx_en) begin
      addr_r  <= addr_nxt;
      valid_r <= (cmd_r == CMD_ADD) || rd_ok;
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  assign sts.clr_last = (clr_addr_r == {AW{1'b1}});

  always_comb begin
    sat_inc   = (ram_rdata == {COUNT_BITS{1'b1}}) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
    ram_we    = cmd.clr_en || (cmd.upd_en && valid_r);
    ram_waddr = cmd.clr_en ? clr_addr_r : addr_r;
    ram_wdata = (cmd.upd_en && (cmd_r == CMD_ADD)) ? sat_inc : '0;
    cnt_ext   = 64'(ram_rdata);
    cnt_sat   = (|cnt_ext[63:32]) ? {OUT_W{1'b1}} : cnt_ext[31:0];
  end

  tdph_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.upd_en && (cmd_r == CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_en) begin
      out_count_r <= valid_r ? cnt_sat : '0;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_bin_count = out_count_r;

endmodule

### hdl/two_d_position_histogram.sv
// out_strobe is high for one cycle, registered from the write-back state, and only for read requests
// a new request is taken only once the controller has stepped through capture,
// multiply, index, memory read and write-back and busy has dropped
// reset: config returns to defaults, then busy stays high until 2^(log2 MAX_BINS_X + log2 MAX_BINS_Y)
// counter entries (4096 by default) are cleared; the receiver cannot stall
module two_d_position_histogram #(
  parameter int MAX_BINS_X = 64,
  parameter int MAX_BINS_Y = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tdph_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tdph_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_cmd,
  input  logic [tdph_pkg::POS_W-1:0]         in_x_position,
  input  logic [tdph_pkg::POS_W-1:0]         in_y_position,
  input  logic [tdph_pkg::RD_IDX_W-1:0]      in_read_bin_x,
  input  logic [tdph_pkg::RD_IDX_W-1:0]      in_read_bin_y,
  input  logic                               in_last_in_snapshot,
  output logic                               out_strobe,
  output logic [tdph_pkg::OUT_W-1:0]         out_bin_count
);
  import tdph_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  tdph_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tdph_dp #(
    .MAX_BINS_X (MAX_BINS_X),
    .MAX_BINS_Y (MAX_BINS_Y),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_cmd        (in_cmd),
    .in_x_position (in_x_position),
    .in_y_position (in_y_position),
    .in_read_bin_x (in_read_bin_x),
    .in_read_bin_y (in_read_bin_y),
    .out_strobe    (out_strobe),
    .out_bin_count (out_bin_count)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while a request is in flight");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe on consecutive cycles");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (busy && !out_strobe))
    else $error("memory clear not started after reset");

endmodule

### tb/sv/tb_top.sv
module tb_top;
  import tdph_pkg::*;

  localparam int NBX = 64;
  localparam int NBY = 64;
  localparam int RUN_PHASES = 8;
  localparam int PHASE_REQS = 117;

  class histogram_scoreboard;
    bit [BINS_REG_W-1:0] bins_x_reg;
    bit [BINS_REG_W-1:0] bins_y_reg;
    bit [INV_W-1:0]      inv_x;
    bit [INV_W-1:0]      inv_y;
    bit [31:0]           counts [NBX*NBY];
    bit [OUT_W-1:0]      read_counts [$];
    bit [11:0]           hot_bins [$];
    int                  errors;

    function void clear_all();
      foreach (counts[i]) counts[i] = '0;
      read_counts.delete();
      hot_bins.delete();
      bins_x_reg = BINS_RESET;
      bins_y_reg = BINS_RESET;
      inv_x = INV_WID_RESET;
      inv_y = INV_WID_RESET;
      errors = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
      case (idx)
        REG_BINS_X:    bins_x_reg = val[BINS_REG_W-1:0];
        REG_BINS_Y:    bins_y_reg = val[BINS_REG_W-1:0];
        REG_INV_WID_X: inv_x = val[INV_W-1:0];
        REG_INV_WID_Y: inv_y = val[INV_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned axis_bin(bit [31:0] pos, bit [31:0] inv, bit [BINS_REG_W-1:0] nreg,
                                   int unsigned limit);
      bit [63:0]   prod;
      bit [31:0]   idx;
      int unsigned in_use;
      prod = {32'd0, pos} * {32'd0, inv};
      idx = prod[63:32];
      in_use = (nreg == 0) ? 1 : ((nreg > limit) ? limit : nreg);
      if (idx >= in_use) idx = in_use - 1;
      return idx;
    endfunction

    function void note_request(bit cmd, bit [31:0] xp, bit [31:0] yp, bit [5:0] rx, bit [5:0] ry);
      int unsigned bx;
      int unsigned by;
      int unsigned a;
      if (cmd == CMD_ADD) begin
        bx = axis_bin(xp, inv_x, bins_x_reg, NBX);
        by = axis_bin(yp, inv_y, bins_y_reg, NBY);
        a = bx * NBY + by;
        if (counts[a] != '1) counts[a]++;
        hot_bins.push_back({bx[5:0], by[5:0]});
        if (hot_bins.size() > 16) void'(hot_bins.pop_front());
      end else begin
        a = int'(rx) * NBY + int'(ry);
        read_counts.push_back(counts[a]);
        counts[a] = '0;
      end
    endfunction

    function void check_count(logic [OUT_W-1:0] got);
      bit [OUT_W-1:0] want;
      if (read_counts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected bin count %0d with no read pending", got);
        return;
      end
      want = read_counts.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("bin count mismatch: expected %0d got %0d", want, got);
      end
    endfunction

    function int pending();
      return read_counts.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  start;
  logic                  busy;
  logic                  in_cmd;
  logic [POS_W-1:0]      in_x_position;
  logic [POS_W-1:0]      in_y_position;
  logic [RD_IDX_W-1:0]   in_read_bin_x;
  logic [RD_IDX_W-1:0]   in_read_bin_y;
  logic                  in_last_in_snapshot;
  logic                  out_strobe;
  logic [OUT_W-1:0]      out_bin_count;

  histogram_scoreboard sb;
  bit                  idle_enable;

  two_d_position_histogram DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_x_position(in_x_position),
    .in_y_position(in_y_position),
    .in_read_bin_x(in_read_bin_x),
    .in_read_bin_y(in_read_bin_y),
    .in_last_in_snapshot(in_last_in_snapshot),
    .out_strobe(out_strobe),
    .out_bin_count(out_bin_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_count(out_bin_count);
      if (start && !busy) begin
        sb.note_request(in_cmd, in_x_position, in_y_position, in_read_bin_x, in_read_bin_y);
      end
    end
  end

  task automatic send_request(bit cmd, bit [31:0] xp, bit [31:0] yp, bit [5:0] rx,
                              bit [5:0] ry, bit last);
    @(negedge clk);
    start <= 1'b1;
    in_cmd <= cmd;
    in_x_position <= xp;
    in_y_position <= yp;
    in_read_bin_x <= rx;
    in_read_bin_y <= ry;
    in_last_in_snapshot <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic add_sample(bit [31:0] xp, bit [31:0] yp, bit last);
    send_request(CMD_ADD, xp, yp, 6'($urandom), 6'($urandom), last);
  endtask

  task automatic read_bin(bit [5:0] rx, bit [5:0] ry);
    send_request(CMD_READ, $urandom, $urandom, rx, ry, 1'($urandom));
  endtask

  task automatic idle_cycles(int n);
    int k;
    k = 0;
    while (k < n) begin
      @(negedge clk);
      start <= 1'b0;
      if (!busy) k++;
    end
  endtask

  // hold off until every read has returned, then let trailing adds finish
  task automatic drain_results();
    idle_cycles(1);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_setting(bit [6:0] bx, bit [6:0] by, bit [31:0] ix, bit [31:0] iy);
    bit [CFG_IDX_W-1:0] idx [4];
    bit [CFG_DATA_W-1:0] val [4];
    idx = '{REG_BINS_X, REG_BINS_Y, REG_INV_WID_X, REG_INV_WID_Y};
    val = '{32'(bx), 32'(by), ix, iy};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      sb.write_reg(idx[i], val[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bit [6:0] pick_bins();
    case ($urandom_range(5))
      0: return 7'd1;
      1: return 7'd64;
      2: return 7'd0;
      3: return 7'($urandom_range(65, 127));
      4: return 7'($urandom_range(2, 8));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic bit [31:0] pick_inv();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return INV_WID_RESET;
      3: return $urandom;
      default: return $urandom_range(32'h0000_4000, 32'h0010_0000);
    endcase
  endfunction

  function automatic bit [31:0] pick_pos();
    if ($urandom_range(9) < 3) return $urandom;
    return $urandom_range(0, 32'h000F_FFFF);
  endfunction

  task automatic random_request();
    bit [11:0] pick;
    if (idle_enable && $urandom_range(99) < 26) idle_cycles($urandom_range(1, 2));
    if ($urandom_range(9) < 7) begin
      add_sample(pick_pos(), pick_pos(), 1'($urandom));
    end else if (sb.hot_bins.size() > 0 && $urandom_range(9) < 6) begin
      pick = sb.hot_bins[$urandom_range(sb.hot_bins.size() - 1)];
      read_bin(pick[11:6], pick[5:0]);
    end else begin
      read_bin(6'($urandom), 6'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.clear_all();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    start = 1'b0;
    in_cmd = CMD_ADD;
    in_x_position = '0;
    in_y_position = '0;
    in_read_bin_x = '0;
    in_read_bin_y = '0;
    in_last_in_snapshot = 1'b0;
    idle_enable = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setting
    add_sample(32'd0, 32'd0, 1'b1);
    add_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_sample(32'h0003_8000, 32'h0005_0000, 1'b0);
    add_sample(32'h0028_0000, 32'h0028_0000, 1'b1);
    read_bin(6'd0, 6'd0);
    read_bin(6'd63, 6'd63);
    read_bin(6'd3, 6'd5);
    read_bin(6'd3, 6'd5);
    read_bin(6'd10, 6'd20);

    // single bin, widest reciprocal; stale count beyond bins in use
    drain_results();
    apply_setting(7'd1, 7'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_sample(32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
    read_bin(6'd0, 6'd0);
    read_bin(6'd40, 6'd40);

    // zero bins acts as one, oversized bins clamps, zero reciprocal
    drain_results();
    apply_setting(7'd0, 7'd127, 32'd0, 32'hFFFF_FFFF);
    add_sample(32'hFFFF_FFFF, 32'd2, 1'b0);
    add_sample(32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    read_bin(6'd0, 6'd1);
    read_bin(6'd0, 6'd63);

    for (int p = 0; p < RUN_PHASES; p++) begin
      drain_results();
      apply_setting(pick_bins(), pick_bins(), pick_inv(), pick_inv());
      idle_enable = (p != 3);
      for (int i = 0; i < PHASE_REQS; i++) begin
        if (p == 1 && i == PHASE_REQS / 2) drain_results();
        random_request();
      end
    end

    idle_cycles(1);
    for (int w = 0; w < 500 && sb.pending() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
